/* rtl/md5_message_digest_assert.svh */
// assertion macros for the md5 message digest checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef MD5_MESSAGE_DIGEST_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define MD5_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define MD5_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/md5_pkg.sv */
// shared types, constants and round tables of the md5 message digest engine
// no dependencies; imported by the top level and its checker
package md5_pkg;

  // input item kinds carried on tuser
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_LAST = 2'd1,
    KIND_END  = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPRESS,
    ST_PAD,
    ST_FINAL
  } state_e;

  // initial chaining vector
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  // the length field starts at this block offset
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'h3F;

  localparam int unsigned TOTAL_W = 61;

  // additive constant of each round
  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // left rotate amount of each round
  function automatic logic [4:0] round_s(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

endpackage

/* rtl/md5_message_digest.sv */
// MD5 message digest engine: byte stream in, 128-bit digest out in two halves.
// A data byte is written into the block store when taken. When a byte completes a
// 64-byte block, the engine runs the 64 rounds on one shared round unit, one round
// per cycle, and is not ready until the last round is done. An end item (tuser 1
// with a byte, or 2 without) writes the pad byte, zeros and the 64-bit bit length
// into the block store one byte per cycle, compressing each block it fills, and the
// digest is loaded once the output register is empty. The digest
// leaves as two transfers from an output register, first half first; the engine
// takes new bytes while they wait. tuser 3 is accepted and ignored.
// Depends on md5_pkg.
module md5_message_digest
  import md5_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [63:0] digest_half
  output logic        m_axis_tuser_o,   // [0] half_index
  output logic        m_axis_tlast_o    // is_final
);

  // control state
  state_e               state_q, state_d;
  logic [5:0]           pos_q, pos_d;
  logic [5:0]           round_q, round_d;
  logic [TOTAL_W-1:0]   total_q, total_d;
  logic                 fin_q, fin_d;
  logic                 first_q, first_d;
  logic                 lenph_q, lenph_d;
  logic [3:0][31:0]     chain_q, chain_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_half_q, out_half_d;

  // payload registers
  logic [15:0][31:0]    block_q;
  logic [31:0]          a_q, b_q, c_q, d_q;
  logic [127:0]         digest_q;

  // datapath controls
  logic                 wr_en;
  logic [7:0]           wr_byte;
  logic                 load_abcd;
  logic                 round_en;
  logic                 load_digest;

  // round unit signals
  logic [3:0]           g_idx;
  logic [31:0]          f_val;
  logic [31:0]          sum_val;
  logic [4:0]           rot_amt;
  logic [63:0]          rot_wide;
  logic [31:0]          b_new;
  logic [63:0]          bit_len;
  logic [7:0]           pad_val;
  logic                 in_xfer;
  logic                 out_xfer;
  kind_e                kind;

  assign kind     = kind_e'(s_axis_tuser_i);
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = out_valid_q && m_axis_tready_i;
  assign bit_len  = {total_q, 3'b000};

  // pad byte at the current block offset
  always_comb begin
    if (first_q) begin
      pad_val = PAD_BYTE;
    end else if (lenph_q) begin
      pad_val = bit_len[{pos_q[2:0], 3'b000} +: 8];
    end else begin
      pad_val = 8'h00;
    end
  end

  // shared round unit: message word select, round function, add and rotate
  always_comb begin
    case (round_q[5:4])
      2'd0: begin
        g_idx = round_q[3:0];
        f_val = (b_q & c_q) | (~b_q & d_q);
      end
      2'd1: begin
        g_idx = round_q[3:0] * 4'd5 + 4'd1;
        f_val = (b_q & d_q) | (c_q & ~d_q);
      end
      2'd2: begin
        g_idx = round_q[3:0] * 4'd3 + 4'd5;
        f_val = b_q ^ c_q ^ d_q;
      end
      default: begin
        g_idx = round_q[3:0] * 4'd7;
        f_val = c_q ^ (b_q | ~d_q);
      end
    endcase
    sum_val  = a_q + f_val + round_k(round_q) + block_q[g_idx];
    rot_amt  = round_s(round_q);
    rot_wide = {sum_val, sum_val} << rot_amt;
    b_new    = b_q + rot_wide[63:32];
  end

  // sequencer: next state and controls
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    round_d     = round_q;
    total_d     = total_q;
    fin_d       = fin_q;
    first_d     = first_q;
    lenph_d     = lenph_q;
    chain_d     = chain_q;
    out_valid_d = out_valid_q;
    out_half_d  = out_half_q;
    wr_en       = 1'b0;
    wr_byte     = s_axis_tdata_i;
    load_abcd   = 1'b0;
    round_en    = 1'b0;
    load_digest = 1'b0;
    s_axis_tready_o = (state_q == ST_IDLE);

    // output register drains one half per transfer
    if (out_xfer) begin
      if (out_half_q) begin
        out_valid_d = 1'b0;
        out_half_d  = 1'b0;
      end else begin
        out_half_d = 1'b1;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (kind)
            KIND_DATA, KIND_LAST: begin
              wr_en   = 1'b1;
              pos_d   = pos_q + 6'd1;
              total_d = total_q + TOTAL_W'(1);
              fin_d   = (kind == KIND_LAST);
              first_d = (kind == KIND_LAST);
              if (pos_q == LAST_POS) begin
                load_abcd = 1'b1;
                round_d   = '0;
                state_d   = ST_COMPRESS;
              end else if (kind == KIND_LAST) begin
                state_d = ST_PAD;
              end
            end
            KIND_END: begin
              fin_d   = 1'b1;
              first_d = 1'b1;
              state_d = ST_PAD;
            end
            default: ;
          endcase
        end
      end
      ST_PAD: begin
        wr_en   = 1'b1;
        wr_byte = pad_val;
        first_d = 1'b0;
        pos_d   = pos_q + 6'd1;
        if (pos_q == LEN_POS - 6'd1) begin
          lenph_d = 1'b1;
        end
        if (pos_q == LAST_POS) begin
          load_abcd = 1'b1;
          round_d   = '0;
          state_d   = ST_COMPRESS;
        end
      end
      ST_COMPRESS: begin
        round_en = 1'b1;
        round_d  = round_q + 6'd1;
        if (round_q == LAST_POS) begin
          chain_d[0] = chain_q[0] + d_q;
          chain_d[1] = chain_q[1] + b_new;
          chain_d[2] = chain_q[2] + b_q;
          chain_d[3] = chain_q[3] + c_q;
          if (!fin_q) begin
            state_d = ST_IDLE;
          end else if (lenph_q) begin
            state_d = ST_FINAL;
          end else begin
            state_d = ST_PAD;
          end
        end
      end
      ST_FINAL: begin
        if (!out_valid_q) begin
          load_digest = 1'b1;
          out_valid_d = 1'b1;
          out_half_d  = 1'b0;
          chain_d     = {IV_D, IV_C, IV_B, IV_A};
          total_d     = '0;
          fin_d       = 1'b0;
          lenph_d     = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      round_q     <= '0;
      total_q     <= '0;
      fin_q       <= 1'b0;
      first_q     <= 1'b0;
      lenph_q     <= 1'b0;
      chain_q     <= {IV_D, IV_C, IV_B, IV_A};
      out_valid_q <= 1'b0;
      out_half_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      round_q     <= round_d;
      total_q     <= total_d;
      fin_q       <= fin_d;
      first_q     <= first_d;
      lenph_q     <= lenph_d;
      chain_q     <= chain_d;
      out_valid_q <= out_valid_d;
      out_half_q  <= out_half_d;
    end
  end

  // block store, working words and digest register
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      block_q[pos_q[5:2]][{pos_q[1:0], 3'b000} +: 8] <= wr_byte;
    end
    if (load_abcd) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
    end else if (round_en) begin
      a_q <= d_q;
      b_q <= b_new;
      c_q <= b_q;
      d_q <= c_q;
    end
    if (load_digest) begin
      digest_q <= chain_q;
    end
  end

  // output port
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_half_q ? digest_q[127:64] : digest_q[63:0];
  assign m_axis_tuser_o  = out_half_q;
  assign m_axis_tlast_o  = out_half_q;

endmodule

/* rtl/md5_message_digest_checker.sv */
// port-level checks of the md5 message digest engine, bound to the top level
// depends on md5_pkg and md5_message_digest_assert.svh
`include "md5_message_digest_assert.svh"

module md5_message_digest_checker
  import md5_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input logic [1:0]  s_axis_tuser_i,   // [1:0] kind
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,   // [63:0] digest_half
  input logic        m_axis_tuser_o,   // [0] half_index
  input logic        m_axis_tlast_o    // is_final
);

  logic in_end;
  logic out_xfer;

  assign in_end   = s_axis_tvalid_i && s_axis_tready_o &&
                    (s_axis_tuser_i == KIND_LAST || s_axis_tuser_i == KIND_END);
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  // a stalled digest half holds
  `MD5_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled output changed")
  // only the second half closes the digest
  `MD5_ASSERT_SAME(a_last_half, m_axis_tvalid_o, m_axis_tlast_o == m_axis_tuser_o, "tlast not on second half")
  // the second half follows the first at once
  `MD5_ASSERT_NEXT(a_half_order, out_xfer && !m_axis_tuser_o, m_axis_tvalid_o && m_axis_tuser_o, "second half missing")
  // no new digest right after the second half leaves
  `MD5_ASSERT_NEXT(a_gap, out_xfer && m_axis_tuser_o, !m_axis_tvalid_o, "digest repeated")
  // an end item starts padding or a compression, so input stalls
  `MD5_ASSERT_NEXT(a_end_busy, in_end, !s_axis_tready_o, "ready during padding")

endmodule

bind md5_message_digest md5_message_digest_checker u_checker (.*);
